@@ design/bqd_pkg.sv @@
package bqd_pkg;

	localparam int PIN_BUTTONS = 4;
	localparam logic [2:0] PIN_ENC_A = 3'd4;
	localparam logic [2:0] PIN_ENC_B = 3'd5;
	localparam logic [16:0] FULL_SCALE = 17'h10000;

	localparam logic signed [1:0] DIR_NONE = 2'sb00;
	localparam logic signed [1:0] DIR_UP = 2'sb01;
	localparam logic signed [1:0] DIR_DOWN = 2'sb11;

	typedef enum logic [2:0] {
		CFG_SHORT_PRESS_MS = 3'd0,
		CFG_LONG_HOLD_MS = 3'd1,
		CFG_PRESS_LEVEL_MASK = 3'd2,
		CFG_LINEAR_STEP = 3'd3,
		CFG_STEPS_PER_TURN = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] short_press_ms;
		logic [15:0] long_hold_ms;
		logic [3:0] press_level_mask;
		logic [16:0] linear_step;
		logic [15:0] steps_per_turn;
	} cfg_t;

	// Quadrature transition table, indexed by previous and current A/B bits.
	function automatic logic signed [1:0] quad_dir(input logic [1:0] prev_ab,
			input logic [1:0] cur_ab);
		logic signed [1:0] dir;
		dir = DIR_NONE;
		case ({prev_ab, cur_ab})
			4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = DIR_UP;
			4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = DIR_DOWN;
			default: dir = DIR_NONE;
		endcase
		return dir;
	endfunction

endpackage

@@ design/bqd_button.sv @@
module bqd_button #(
	parameter int TIME_BITS = 32,
	parameter int BUTTON_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input logic [2:0] pin,
	input logic level,
	input logic [TIME_BITS-1:0] now,
	input bqd_pkg::cfg_t cfg,
	output logic short_press,
	output logic long_hold
);

	localparam int BTN_N = (BUTTON_COUNT < bqd_pkg::PIN_BUTTONS) ?
		BUTTON_COUNT : bqd_pkg::PIN_BUTTONS;

	logic [TIME_BITS-1:0] edge_time_q [BTN_N];
	logic [BTN_N-1:0] sel;
	logic [TIME_BITS-1:0] edge_sel;
	logic [TIME_BITS-1:0] held;
	logic press;
	logic short_n;
	logic long_n;

	always_comb begin
		edge_sel = '0;
		for (int i = 0; i < BTN_N; i++) begin
			sel[i] = (pin == 3'(i));
			if (sel[i]) begin
				edge_sel = edge_time_q[i];
			end
		end
		press = (level == cfg.press_level_mask[pin[1:0]]);
		held = now - edge_sel;
		long_n = !press && (held > TIME_BITS'(cfg.long_hold_ms));
		short_n = !press && (held > TIME_BITS'(cfg.short_press_ms))
			&& (held <= TIME_BITS'(cfg.long_hold_ms));
	end

	// The flags of a button depend only on the current event, so only the edge time is kept.
	assign short_press = (|sel) && short_n;
	assign long_hold = (|sel) && long_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BTN_N; i++) begin
				edge_time_q[i] <= '0;
			end
		end else if (upd) begin
			for (int i = 0; i < BTN_N; i++) begin
				if (sel[i]) begin
					edge_time_q[i] <= now;
				end
			end
		end
	end

endmodule

@@ design/bqd_encoder.sv @@
module bqd_encoder (
	input logic clk,
	input logic arst_n,
	input logic upd,
	input logic [2:0] pin,
	input logic level,
	input logic last_in_batch,
	input bqd_pkg::cfg_t cfg,
	output logic signed [1:0] step_direction,
	output logic [16:0] linear_position,
	output logic [15:0] angle_steps
);

	logic [1:0] cur_q;
	logic [1:0] prev_q;
	logic pend_q;
	logic [16:0] lin_q;
	logic [15:0] angle_q;

	logic [1:0] cur_n;
	logic [1:0] prev_n;
	logic pend_n;
	logic run;
	logic signed [1:0] dir;
	logic [17:0] lin_sum;
	logic [16:0] lin_up;
	logic [16:0] lin_down;
	logic [15:0] spt;
	logic [16:0] angle_inc;
	logic [15:0] angle_up;
	logic [15:0] angle_down;

	always_comb begin
		cur_n = cur_q;
		pend_n = pend_q;
		if (pin == bqd_pkg::PIN_ENC_A) begin
			cur_n[0] = level;
			pend_n = 1'b1;
		end else if (pin == bqd_pkg::PIN_ENC_B) begin
			cur_n[1] = level;
			pend_n = 1'b1;
		end
		run = last_in_batch && pend_n;
		prev_n = prev_q;
		dir = bqd_pkg::DIR_NONE;
		if (run) begin
			dir = bqd_pkg::quad_dir(prev_q, cur_n);
			prev_n = cur_n;
			pend_n = 1'b0;
		end

		lin_sum = {1'b0, lin_q} + {1'b0, cfg.linear_step};
		lin_up = (lin_sum > {1'b0, bqd_pkg::FULL_SCALE}) ? bqd_pkg::FULL_SCALE : lin_sum[16:0];
		lin_down = (cfg.linear_step >= lin_q) ? '0 : lin_q - cfg.linear_step;

		spt = (cfg.steps_per_turn == '0) ? 16'd1 : cfg.steps_per_turn;
		angle_inc = {1'b0, angle_q} + 17'd1;
		angle_up = (angle_inc >= {1'b0, spt}) ? '0 : angle_inc[15:0];
		angle_down = (angle_q == '0 || angle_q >= spt) ? spt - 16'd1 : angle_q - 16'd1;

		step_direction = dir;
		linear_position = lin_q;
		angle_steps = angle_q;
		if (dir == bqd_pkg::DIR_UP) begin
			linear_position = lin_up;
			angle_steps = angle_up;
		end else if (dir == bqd_pkg::DIR_DOWN) begin
			linear_position = lin_down;
			angle_steps = angle_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			prev_q <= '0;
			pend_q <= 1'b0;
			lin_q <= '0;
			angle_q <= '0;
		end else if (upd) begin
			cur_q <= cur_n;
			prev_q <= prev_n;
			pend_q <= pend_n;
			lin_q <= linear_position;
			angle_q <= angle_steps;
		end
	end

endmodule

@@ design/button_timing_and_quadrature_decoder.sv @@
// A result passes through the input register and then the result register once its input transaction is accepted.
// Throughput: one transaction per cycle while out_ready is high, set by the input register and result register pair.
// Input is accepted while a finished result waits, as long as the input stage is empty or can move on.
// Reset: arst_n asynchronously clears all button, encoder and handshake state,
// and returns the configuration registers to their default values.
module button_timing_and_quadrature_decoder #(
	parameter int TIME_BITS = 32,
	parameter int BUTTON_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] pin,
	input logic level,
	input logic [31:0] timestamp_ms,
	input logic last_in_batch,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] pin_echo,
	output logic short_press,
	output logic long_hold,
	output logic signed [1:0] step_direction,
	output logic [16:0] linear_position,
	output logic [15:0] angle_steps,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [16:0] cfg_data
);

	bqd_pkg::cfg_t cfg_q;

	logic valid_s1;
	logic [2:0] pin_s1;
	logic level_s1;
	logic [31:0] timestamp_s1;
	logic last_s1;
	logic advance;

	logic valid_s2;
	logic [2:0] pin_s2;
	logic short_s2;
	logic long_s2;
	logic signed [1:0] dir_s2;
	logic [16:0] lin_s2;
	logic [15:0] angle_s2;

	logic [TIME_BITS-1:0] now_s1;
	logic btn_short;
	logic btn_long;
	logic signed [1:0] enc_dir;
	logic [16:0] enc_lin;
	logic [15:0] enc_angle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_press_ms <= 16'd50;
			cfg_q.long_hold_ms <= 16'd1000;
			cfg_q.press_level_mask <= 4'd0;
			cfg_q.linear_step <= 17'd655;
			cfg_q.steps_per_turn <= 16'd48;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bqd_pkg::CFG_SHORT_PRESS_MS: cfg_q.short_press_ms <= cfg_data[15:0];
				bqd_pkg::CFG_LONG_HOLD_MS: cfg_q.long_hold_ms <= cfg_data[15:0];
				bqd_pkg::CFG_PRESS_LEVEL_MASK: cfg_q.press_level_mask <= cfg_data[3:0];
				bqd_pkg::CFG_LINEAR_STEP: cfg_q.linear_step <= cfg_data;
				bqd_pkg::CFG_STEPS_PER_TURN: cfg_q.steps_per_turn <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin;
			level_s1 <= level;
			timestamp_s1 <= timestamp_ms;
			last_s1 <= last_in_batch;
		end
	end

	assign now_s1 = TIME_BITS'(timestamp_s1);

	bqd_button #(
		.TIME_BITS(TIME_BITS),
		.BUTTON_COUNT(BUTTON_COUNT)
	) u_button (
		.clk(clk),
		.arst_n(arst_n),
		.upd(advance),
		.pin(pin_s1),
		.level(level_s1),
		.now(now_s1),
		.cfg(cfg_q),
		.short_press(btn_short),
		.long_hold(btn_long)
	);

	bqd_encoder u_encoder (
		.clk(clk),
		.arst_n(arst_n),
		.upd(advance),
		.pin(pin_s1),
		.level(level_s1),
		.last_in_batch(last_s1),
		.cfg(cfg_q),
		.step_direction(enc_dir),
		.linear_position(enc_lin),
		.angle_steps(enc_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pin_s2 <= pin_s1;
			short_s2 <= btn_short;
			long_s2 <= btn_long;
			dir_s2 <= enc_dir;
			lin_s2 <= enc_lin;
			angle_s2 <= enc_angle;
		end
	end

	assign out_valid = valid_s2;
	assign pin_echo = pin_s2;
	assign short_press = short_s2;
	assign long_hold = long_s2;
	assign step_direction = dir_s2;
	assign linear_position = lin_s2;
	assign angle_steps = angle_s2;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> linear_position <= bqd_pkg::FULL_SCALE)
		else $error("Linear position above full scale.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(short_press && long_hold))
		else $error("Short press and long hold reported together.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_echo >= 3'd4 |-> !short_press && !long_hold)
		else $error("Button flags set for a non-button pin.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_direction != bqd_pkg::DIR_NONE |-> pin_echo <= 3'd7
			&& step_direction != 2'sb10)
		else $error("Invalid step direction code.");
`endif

endmodule

@@ tb/sv/bqd_result_checker.sv @@
module bqd_result_checker
	import bqd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [2:0] pin,
	input logic level,
	input logic [31:0] timestamp_ms,
	input logic last_in_batch,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] pin_echo,
	input logic short_press,
	input logic long_hold,
	input logic signed [1:0] step_direction,
	input logic [16:0] linear_position,
	input logic [15:0] angle_steps,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [16:0] cfg_data,
	output int fail_count,
	output int results_pending,
	output int results_seen,
	output int forward_steps,
	output int reverse_steps,
	output int short_presses,
	output int long_holds,
	output int cfg_writes
);

	typedef struct packed {
		logic [2:0] pin;
		logic short_press;
		logic long_hold;
		logic signed [1:0] dir;
		logic [16:0] position;
		logic [15:0] angle;
	} event_result_t;

	cfg_t cfg;
	logic [PIN_BUTTONS-1:0] btn_short;
	logic [PIN_BUTTONS-1:0] btn_long;
	logic [31:0] btn_edge_ms [PIN_BUTTONS];
	logic [1:0] enc_ab;
	logic [1:0] enc_prev_ab;
	logic enc_pending;
	logic [16:0] position;
	logic [15:0] angle;
	event_result_t predicted_reports[$];
	event_result_t want;
	event_result_t got;

	// The A/B lines follow a Gray sequence, so a step is the difference of positions mod 4.
	function automatic logic [1:0] gray_position(input logic [1:0] ab);
		return {ab[1], ab[1] ^ ab[0]};
	endfunction

	function automatic event_result_t decode_event(input logic [2:0] p, input logic lvl,
			input logic [31:0] ts, input logic last);
		event_result_t r;
		logic [31:0] held;
		logic [1:0] delta;
		logic [17:0] sum;
		logic [15:0] turn;
		r = '0;
		r.pin = p;
		r.dir = DIR_NONE;
		if (p < PIN_BUTTONS) begin
			if (lvl == cfg.press_level_mask[p]) begin
				btn_short[p] = 1'b0;
				btn_long[p] = 1'b0;
			end else begin
				held = ts - btn_edge_ms[p];
				btn_long[p] = held > cfg.long_hold_ms;
				btn_short[p] = held > cfg.short_press_ms && held <= cfg.long_hold_ms;
			end
			btn_edge_ms[p] = ts;
			r.short_press = btn_short[p];
			r.long_hold = btn_long[p];
		end else if (p == PIN_ENC_A) begin
			enc_ab[0] = lvl;
			enc_pending = 1'b1;
		end else if (p == PIN_ENC_B) begin
			enc_ab[1] = lvl;
			enc_pending = 1'b1;
		end
		if (last && enc_pending) begin
			delta = gray_position(enc_ab) - gray_position(enc_prev_ab);
			turn = (cfg.steps_per_turn == 16'd0) ? 16'd1 : cfg.steps_per_turn;
			if (delta == 2'd1) begin
				r.dir = DIR_UP;
				sum = position + cfg.linear_step;
				position = (sum > FULL_SCALE) ? FULL_SCALE : sum[16:0];
				angle = (angle + 1 >= turn) ? 16'd0 : angle + 16'd1;
			end else if (delta == 2'd3) begin
				r.dir = DIR_DOWN;
				position = (cfg.linear_step >= position) ? 17'd0 : position - cfg.linear_step;
				angle = (angle == 16'd0 || angle >= turn) ? turn - 16'd1 : angle - 16'd1;
			end
			enc_prev_ab = enc_ab;
			enc_pending = 1'b0;
		end
		r.position = position;
		r.angle = angle;
		return r;
	endfunction

	task automatic note_failure(input string what);
		if (fail_count < 10) begin
			$display("%0t %s: expected pin %0d sp %0b lh %0b dir %0d pos %0d angle %0d",
				$time, what, want.pin, want.short_press, want.long_hold, want.dir,
				want.position, want.angle);
			$display("%0t %s: got pin %0d sp %0b lh %0b dir %0d pos %0d angle %0d",
				$time, what, got.pin, got.short_press, got.long_hold, got.dir,
				got.position, got.angle);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.short_press_ms = 16'd50;
			cfg.long_hold_ms = 16'd1000;
			cfg.press_level_mask = 4'd0;
			cfg.linear_step = 17'd655;
			cfg.steps_per_turn = 16'd48;
			btn_short = '0;
			btn_long = '0;
			for (int i = 0; i < PIN_BUTTONS; i++)
				btn_edge_ms[i] = '0;
			enc_ab = '0;
			enc_prev_ab = '0;
			enc_pending = 1'b0;
			position = '0;
			angle = '0;
			predicted_reports.delete();
			fail_count = 0;
			results_pending = 0;
			results_seen = 0;
			forward_steps = 0;
			reverse_steps = 0;
			short_presses = 0;
			long_holds = 0;
			cfg_writes = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_SHORT_PRESS_MS: cfg.short_press_ms = cfg_data[15:0];
					CFG_LONG_HOLD_MS: cfg.long_hold_ms = cfg_data[15:0];
					CFG_PRESS_LEVEL_MASK: cfg.press_level_mask = cfg_data[3:0];
					CFG_LINEAR_STEP: cfg.linear_step = cfg_data;
					CFG_STEPS_PER_TURN: cfg.steps_per_turn = cfg_data[15:0];
					default: ;
				endcase
				cfg_writes++;
			end
			if (out_valid && out_ready) begin
				got = {pin_echo, short_press, long_hold, step_direction, linear_position,
					angle_steps};
				results_seen++;
				if (got.dir == DIR_UP)
					forward_steps++;
				if (got.dir == DIR_DOWN)
					reverse_steps++;
				if (got.short_press)
					short_presses++;
				if (got.long_hold)
					long_holds++;
				if (predicted_reports.size() == 0) begin
					want = '0;
					note_failure("result with no transaction outstanding");
				end else begin
					want = predicted_reports.pop_front();
					if (got.pin !== want.pin || got.short_press !== want.short_press ||
							got.long_hold !== want.long_hold || got.dir !== want.dir ||
							got.position !== want.position || got.angle !== want.angle)
						note_failure("result mismatch");
				end
			end
			if (in_valid && in_ready)
				predicted_reports.push_back(decode_event(pin, level, timestamp_ms,
					last_in_batch));
			results_pending = predicted_reports.size();
		end
	end

endmodule

@@ tb/sv/button_timing_and_quadrature_decoder_tb.sv @@
module button_timing_and_quadrature_decoder_tb;
	import bqd_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] pin;
	logic level;
	logic [31:0] timestamp_ms;
	logic last_in_batch;
	logic out_valid;
	logic out_ready;
	logic [2:0] pin_echo;
	logic short_press;
	logic long_hold;
	logic signed [1:0] step_direction;
	logic [16:0] linear_position;
	logic [15:0] angle_steps;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [16:0] cfg_data;

	int fail_count;
	int results_pending;
	int results_seen;
	int forward_steps;
	int reverse_steps;
	int short_presses;
	int long_holds;
	int cfg_writes;

	int gap_limit;
	int stall_limit;
	int events_sent;
	bit hold_request;
	logic [31:0] now_ms;
	logic [1:0] lines_ab;
	logic [3:0] press_mask;
	logic [15:0] short_ms;
	logic [15:0] long_ms;

	button_timing_and_quadrature_decoder DUT (.*);

	bqd_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_event(input logic [2:0] p, input logic lvl, input logic [31:0] ts,
			input logic last);
		int gap;
		gap = $urandom_range(0, gap_limit);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pin <= p;
		level <= lvl;
		timestamp_ms <= ts;
		last_in_batch <= last;
		do @(posedge clk); while (!in_ready);
		events_sent++;
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [16:0] value);
		in_valid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SHORT_PRESS_MS: short_ms = value[15:0];
			CFG_LONG_HOLD_MS: long_ms = value[15:0];
			CFG_PRESS_LEVEL_MASK: press_mask = value[3:0];
			default: ;
		endcase
	endtask

	task automatic turn_encoder(input bit up, input logic last);
		logic [2:0] p;
		// Stepping up from an even Gray position, or down from an odd one, flips channel A.
		p = ((lines_ab[0] ^ lines_ab[1]) != up) ? PIN_ENC_A : PIN_ENC_B;
		if (p == PIN_ENC_A)
			lines_ab[0] = ~lines_ab[0];
		else
			lines_ab[1] = ~lines_ab[1];
		send_event(p, (p == PIN_ENC_A) ? lines_ab[0] : lines_ab[1], now_ms, last);
	endtask

	task automatic press_button(input logic [1:0] b, input logic [31:0] held);
		send_event({1'b0, b}, press_mask[b], now_ms, 1'($urandom));
		if ($urandom_range(0, 3) == 0)
			turn_encoder(1'($urandom), 1'b1);
		now_ms += held;
		send_event({1'b0, b}, ~press_mask[b], now_ms, 1'($urandom));
	endtask

	initial begin : receiver
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				stall = 300;
			end else begin
				stall = $urandom_range(0, stall_limit);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int phase_goal;
		int action;
		int up_pct;
		logic [31:0] held;
		logic [2:0] noise_pin;
		logic noise_level;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pin = '0;
		level = 1'b0;
		timestamp_ms = '0;
		last_in_batch = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SHORT_PRESS_MS;
		cfg_data = '0;
		gap_limit = 6;
		stall_limit = 6;
		hold_request = 1'b0;
		events_sent = 0;
		lines_ab = '0;
		press_mask = 4'd0;
		short_ms = 16'd50;
		long_ms = 16'd1000;
		now_ms = $urandom;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encoder special cases at the reset settings: reverse step at zero, ignored pin
		// closing a batch, batch end with nothing pending, no change, double change, wrap.
		send_event(PIN_ENC_B, 1'b1, 32'd5, 1'b1);
		send_event(PIN_ENC_A, 1'b1, 32'd6, 1'b0);
		send_event(3'd6, 1'b1, 32'd7, 1'b1);
		send_event(3'd7, 1'b0, 32'd8, 1'b1);
		send_event(PIN_ENC_A, 1'b1, 32'd9, 1'b1);
		send_event(PIN_ENC_A, 1'b0, 32'd10, 1'b0);
		send_event(PIN_ENC_B, 1'b0, 32'd11, 1'b1);
		send_event(PIN_ENC_A, 1'b1, 32'd12, 1'b1);
		send_event(PIN_ENC_A, 1'b0, 32'd13, 1'b1);
		// Button timing on both sides of each threshold, a timestamp wrap and a release
		// without a press.
		send_event(3'd0, 1'b0, 32'd100, 1'b0);
		send_event(3'd0, 1'b1, 32'd150, 1'b0);
		send_event(3'd0, 1'b0, 32'd200, 1'b0);
		send_event(3'd0, 1'b1, 32'd251, 1'b0);
		send_event(3'd1, 1'b0, 32'd1000, 1'b0);
		send_event(3'd1, 1'b1, 32'd2000, 1'b0);
		send_event(3'd1, 1'b0, 32'd3000, 1'b0);
		send_event(3'd1, 1'b1, 32'd4001, 1'b0);
		send_event(3'd2, 1'b0, 32'hFFFF_FFF0, 1'b0);
		send_event(3'd2, 1'b1, 32'h0000_0100, 1'b1);
		send_event(3'd3, 1'b1, 32'hFFFF_FFFF, 1'b1);
		send_event(3'd3, 1'b0, 32'd0, 1'b0);
		send_event(3'd3, 1'b0, 32'd5, 1'b1);
		lines_ab = 2'b00;

		for (int ph = 1; ph <= 7; ph++) begin
			case (ph)
				1: begin
					write_reg(CFG_SHORT_PRESS_MS, 17'd0);
					write_reg(CFG_LONG_HOLD_MS, 17'd65535);
					write_reg(CFG_PRESS_LEVEL_MASK, 17'd15);
					write_reg(CFG_LINEAR_STEP, 17'd65536);
					write_reg(CFG_STEPS_PER_TURN, 17'd1);
				end
				2: begin
					write_reg(CFG_SHORT_PRESS_MS, 17'd65535);
					write_reg(CFG_LONG_HOLD_MS, 17'd0);
					write_reg(CFG_PRESS_LEVEL_MASK, 17'd0);
					write_reg(CFG_LINEAR_STEP, 17'd0);
					write_reg(CFG_STEPS_PER_TURN, 17'd0);
				end
				3: begin
					write_reg(CFG_SHORT_PRESS_MS, 17'($urandom_range(0, 200)));
					write_reg(CFG_LONG_HOLD_MS, 17'($urandom_range(200, 3000)));
					write_reg(CFG_PRESS_LEVEL_MASK, 17'($urandom));
					write_reg(CFG_LINEAR_STEP, 17'($urandom));
					write_reg(CFG_STEPS_PER_TURN, 17'($urandom_range(50, 1000)));
				end
				4: begin
					// Lowering the turn size below the current angle.
					write_reg(CFG_LINEAR_STEP, 17'($urandom_range(1, 4000)));
					write_reg(CFG_STEPS_PER_TURN, 17'd3);
				end
				default: begin
					write_reg(CFG_SHORT_PRESS_MS, {1'($urandom), 16'($urandom_range(0, 300))});
					write_reg(CFG_LONG_HOLD_MS, 17'($urandom));
					write_reg(CFG_PRESS_LEVEL_MASK, 17'($urandom));
					write_reg(CFG_LINEAR_STEP, 17'($urandom_range(0, 20000)));
					write_reg(CFG_STEPS_PER_TURN, ($urandom_range(0, 1) == 0) ?
						17'($urandom_range(1, 64)) : 17'($urandom));
				end
			endcase
			up_pct = (ph == 3) ? 90 : $urandom_range(20, 80);
			if (ph == 1) begin
				gap_limit = 0;
				hold_request = 1'b1;
			end
			phase_goal = events_sent + 100;
			while (events_sent < phase_goal) begin
				if ($urandom_range(0, 24) == 0) begin
					gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 6;
					stall_limit = ($urandom_range(0, 2) == 0) ? 0 : 6;
				end
				if ($urandom_range(0, 30) == 0)
					now_ms = $urandom;
				else
					now_ms += $urandom_range(1, 40);
				action = $urandom_range(0, 9);
				if (action < 4) begin
					case ($urandom_range(0, 7))
						0: held = short_ms;
						1: held = short_ms + 32'd1;
						2: held = long_ms;
						3: held = long_ms + 32'd1;
						4: held = $urandom_range(0, 2000);
						5: held = $urandom;
						6: held = short_ms - 32'd1;
						default: held = $urandom_range(0, long_ms + 10);
					endcase
					press_button(2'($urandom), held);
				end else if (action < 8) begin
					turn_encoder($urandom_range(1, 100) <= up_pct, $urandom_range(0, 3) != 0);
				end else begin
					noise_pin = 3'($urandom);
					noise_level = 1'($urandom);
					if (noise_pin == PIN_ENC_A)
						lines_ab[0] = noise_level;
					else if (noise_pin == PIN_ENC_B)
						lines_ab[1] = noise_level;
					send_event(noise_pin, noise_level, $urandom, 1'($urandom));
				end
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (results_pending != 0);
		repeat (4) @(posedge clk);
		$display("Checked %0d events, %0d register writes, %0d short presses, %0d long holds.",
			results_seen, cfg_writes, short_presses, long_holds);
		$display("Encoder decoded %0d forward and %0d reverse steps over saturation and wrap.",
			forward_steps, reverse_steps);
		if (fail_count == 0 && results_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ button_timing_and_quadrature_decoder.f @@
design/bqd_pkg.sv
design/bqd_button.sv
design/bqd_encoder.sv
design/button_timing_and_quadrature_decoder.sv
tb/sv/bqd_result_checker.sv
tb/sv/button_timing_and_quadrature_decoder_tb.sv
